// File: design/bpf_pkg.sv
package bpf_pkg;

    localparam int TRI_SLOTS = 12;
    localparam int BONE_W    = 8;
    localparam int SLOT_IW   = 4;

    typedef logic [BONE_W-1:0]    bone_t;
    typedef bone_t                slots_t [TRI_SLOTS];
    typedef logic [TRI_SLOTS-1:0] slot_mask_t;
    typedef logic [SLOT_IW-1:0]   slot_cnt_t;

    localparam logic [1:0] REG_BONE_LIMIT = 2'd0;
    localparam logic [6:0] BONE_LIMIT_RST = 7'd64;

    function automatic slot_cnt_t count_mask(input slot_mask_t m);
        slot_cnt_t c;
        c = '0;
        for (int i = 0; i < TRI_SLOTS; i++)
        begin
            c = c + slot_cnt_t'(m[i]);
        end
        return c;
    endfunction

endpackage

// File: design/bpf_dedup.sv
module bpf_dedup (
    input  bpf_pkg::slots_t     slots,
    output bpf_pkg::slot_mask_t uniq,
    output bpf_pkg::slot_cnt_t  ntri
);
    import bpf_pkg::*;

    // a slot is kept if it is used and no earlier slot holds the same bone
    always_comb
    begin
        for (int i = 0; i < TRI_SLOTS; i++)
        begin
            uniq[i] = (slots[i] != '0);
            for (int j = 0; j < i; j++)
            begin
                if (slots[j] == slots[i])
                begin
                    uniq[i] = 1'b0;
                end
            end
        end
    end

    assign ntri = count_mask(uniq);

endmodule

// File: design/bone_partition_first_fit.sv
// Places one triangle (twelve 8-bit bone slots, 0 = unused) per transaction into
// first-fit bone partitions of at most bone_limit distinct bones and returns one
// result per triangle. For every open partition tried, the block scans that
// partition's stored bones through the single bone list memory port and checks
// the fit, then appends the new bones one slot at a time, and it waits to issue
// its result while a previous result still waits on m_tready; s_tready is low
// meanwhile. The user must write bone_limit over the APB port at address 0 only
// while the block is idle; the block itself does not enforce this.
module bone_partition_first_fit #(
    parameter int MAX_PARTITIONS = 16,
    parameter int MAX_BONES      = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bone_v0_0, bone_v0_1, .. bone_v2_3, 8 bits each
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // partition_index[3:0], opened_new, rejected, bones_added[3:0],
    // partition_bone_count[6:0], zero fill
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bpf_pkg::*;

    localparam int PW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int OW = $clog2(MAX_PARTITIONS + 1);
    localparam int CW = $clog2(MAX_BONES + 1);
    localparam int AW = (MAX_PARTITIONS * MAX_BONES > 1) ?
                        $clog2(MAX_PARTITIONS * MAX_BONES) : 1;

    typedef enum logic [2:0] {IDLE, SCAN, CHECK, APPEND, DONE} state_t;

    state_t        state_reg;
    logic [6:0]    limit_reg;
    slots_t        slot_reg;
    slot_mask_t    uniq_reg;
    slot_mask_t    present_reg;
    slot_mask_t    mask_reg;
    slot_cnt_t     nmiss_reg;
    slot_cnt_t     i_reg;
    logic [PW-1:0] p_reg;
    logic [OW-1:0] open_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] cnt_reg [MAX_PARTITIONS];
    logic          pend_reg;
    logic          opened_reg;
    logic          rej_reg;
    logic          out_valid_reg;
    logic [23:0]   out_data_reg;

    bone_t         bone_mem [MAX_PARTITIONS * MAX_BONES];
    bone_t         rd_data_reg;

    slots_t        in_slots;
    slot_mask_t    in_uniq;
    slot_cnt_t     in_ntri;
    logic [CW-1:0] eff_limit;
    logic [CW-1:0] cur_cnt;
    logic [CW-1:0] room;
    slot_mask_t    miss_now;
    slot_cnt_t     nmiss_now;
    slot_mask_t    hit;
    logic [AW-1:0] base_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic          cfg_wr;

    always_comb
    begin
        for (int i = 0; i < TRI_SLOTS; i++)
        begin
            in_slots[i] = s_tdata[i*BONE_W +: BONE_W];
        end
    end

    bpf_dedup u_dedup (
        .slots (in_slots),
        .uniq  (in_uniq),
        .ntri  (in_ntri)
    );

    assign eff_limit = (int'(limit_reg) > MAX_BONES) ? CW'(MAX_BONES) : CW'(limit_reg);
    assign cur_cnt   = cnt_reg[p_reg];
    assign room      = (cur_cnt >= eff_limit) ? '0 : eff_limit - cur_cnt;
    assign miss_now  = uniq_reg & ~present_reg;
    assign nmiss_now = count_mask(miss_now);

    always_comb
    begin
        for (int i = 0; i < TRI_SLOTS; i++)
        begin
            hit[i] = (rd_data_reg == slot_reg[i]);
        end
    end

    assign base_addr = AW'(p_reg) * AW'(MAX_BONES);
    assign rd_addr   = base_addr + AW'(k_reg);
    assign wr_addr   = base_addr + AW'(cur_cnt);
    assign wr_en     = (state_reg == APPEND) && mask_reg[i_reg] && (int'(cur_cnt) < MAX_BONES);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bone_mem[wr_addr] <= slot_reg[i_reg];
        end
        rd_data_reg <= bone_mem[rd_addr];
    end

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_BONE_LIMIT) ? {25'd0, limit_reg} : 32'd0;
    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            limit_reg     <= BONE_LIMIT_RST;
            open_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            for (int p = 0; p < MAX_PARTITIONS; p++)
            begin
                cnt_reg[p] <= '0;
            end
        end
        else
        begin
            if (cfg_wr && paddr == REG_BONE_LIMIT)
            begin
                limit_reg <= pwdata[6:0];
            end
            if (out_valid_reg && m_tready && state_reg != DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        slot_reg    <= in_slots;
                        uniq_reg    <= in_uniq;
                        present_reg <= '0;
                        p_reg       <= '0;
                        k_reg       <= '0;
                        pend_reg    <= 1'b0;
                        i_reg       <= '0;
                        opened_reg  <= 1'b0;
                        rej_reg     <= 1'b0;
                        if (CW'(in_ntri) > eff_limit)
                        begin
                            rej_reg   <= 1'b1;
                            state_reg <= DONE;
                        end
                        else if (open_reg == '0)
                        begin
                            open_reg      <= OW'(1);
                            cnt_reg[0]    <= '0;
                            mask_reg      <= in_uniq;
                            nmiss_reg     <= in_ntri;
                            opened_reg    <= 1'b1;
                            state_reg     <= APPEND;
                        end
                        else
                        begin
                            state_reg <= SCAN;
                        end
                    end
                end
                SCAN:
                begin
                    // read data is registered and arrives the cycle after its address
                    if (pend_reg)
                    begin
                        present_reg <= present_reg | hit;
                    end
                    pend_reg <= (k_reg < cur_cnt);
                    if (k_reg < cur_cnt)
                    begin
                        k_reg <= k_reg + CW'(1);
                    end
                    else if (!pend_reg)
                    begin
                        state_reg <= CHECK;
                    end
                end
                CHECK:
                begin
                    if (CW'(nmiss_now) <= room)
                    begin
                        mask_reg  <= miss_now;
                        nmiss_reg <= nmiss_now;
                        state_reg <= APPEND;
                    end
                    else if (OW'(p_reg) + OW'(1) < open_reg)
                    begin
                        p_reg       <= p_reg + PW'(1);
                        k_reg       <= '0;
                        present_reg <= '0;
                        state_reg   <= SCAN;
                    end
                    else if (int'(open_reg) < MAX_PARTITIONS)
                    begin
                        p_reg                      <= PW'(open_reg);
                        cnt_reg[PW'(open_reg)]     <= '0;
                        open_reg                   <= open_reg + OW'(1);
                        mask_reg                   <= uniq_reg;
                        nmiss_reg                  <= count_mask(uniq_reg);
                        opened_reg                 <= 1'b1;
                        state_reg                  <= APPEND;
                    end
                    else
                    begin
                        rej_reg   <= 1'b1;
                        state_reg <= DONE;
                    end
                end
                APPEND:
                begin
                    if (wr_en)
                    begin
                        cnt_reg[p_reg] <= cur_cnt + CW'(1);
                    end
                    if (int'(i_reg) == TRI_SLOTS - 1)
                    begin
                        state_reg <= DONE;
                    end
                    else
                    begin
                        i_reg <= i_reg + slot_cnt_t'(1);
                    end
                end
                DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        if (rej_reg)
                        begin
                            out_data_reg <= 24'h000020;
                        end
                        else
                        begin
                            out_data_reg <= {7'd0, 7'(cur_cnt), nmiss_reg, 1'b0,
                                             opened_reg, 4'(p_reg)};
                        end
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

// File: sim/bone_partition_first_fit_test.sv
module bone_partition_first_fit_test;
    import bpf_pkg::*;

    localparam int NPART     = 16;
    localparam int NBONE     = 64;
    localparam int CYC_LIMIT = 12000000;

    typedef struct packed {
        logic [6:0] bone_cnt;
        logic [3:0] added;
        logic       rejected;
        logic       opened;
        logic [3:0] part;
    } placement_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bone_partition_first_fit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow of the partition build
    bone_t      part_bones [NPART][NBONE];
    int         part_count [NPART];
    int         parts_open;
    int         limit_reg;
    placement_t placements_due [$];
    int         fails;
    int         sent;
    int         placed;
    int         rejects;
    int         cycles;
    bit         quiet;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic bit part_holds(input int p, input bone_t b);
        for (int i = 0; i < part_count[p]; i++)
        begin
            if (part_bones[p][i] == b)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic placement_t place_triangle(input slots_t t);
        bone_t      uniq [TRI_SLOTS];
        bone_t      miss [TRI_SLOTS];
        int         nuniq;
        int         nmiss;
        int         lim;
        int         p;
        int         room;
        bit         dup;
        bit         found;
        bit         opened;
        placement_t r;
        nuniq = 0;
        nmiss = 0;
        found = 1'b0;
        opened = 1'b0;
        lim = (limit_reg > NBONE) ? NBONE : limit_reg;
        for (int i = 0; i < TRI_SLOTS; i++)
        begin
            dup = 1'b0;
            for (int j = 0; j < nuniq; j++)
            begin
                if (uniq[j] == t[i])
                    dup = 1'b1;
            end
            if (t[i] != 0 && !dup)
            begin
                uniq[nuniq] = t[i];
                nuniq++;
            end
        end
        p = 0;
        if (nuniq <= lim)
        begin
            for (p = 0; p < parts_open; p++)
            begin
                room = (part_count[p] >= lim) ? 0 : lim - part_count[p];
                nmiss = 0;
                for (int i = 0; i < nuniq; i++)
                begin
                    if (!part_holds(p, uniq[i]))
                    begin
                        miss[nmiss] = uniq[i];
                        nmiss++;
                    end
                end
                if (nmiss <= room)
                begin
                    found = 1'b1;
                    break;
                end
            end
            if (!found && parts_open < NPART)
            begin
                p = parts_open;
                parts_open++;
                part_count[p] = 0;
                nmiss = nuniq;
                for (int i = 0; i < nuniq; i++)
                    miss[i] = uniq[i];
                found = 1'b1;
                opened = 1'b1;
            end
        end
        r = '0;
        if (!found)
        begin
            r.rejected = 1'b1;
            return r;
        end
        for (int i = 0; i < nmiss; i++)
        begin
            if (part_count[p] < NBONE)
            begin
                part_bones[p][part_count[p]] = miss[i];
                part_count[p]++;
            end
        end
        r.part     = p[3:0];
        r.opened   = opened;
        r.added    = nmiss[3:0];
        r.bone_cnt = part_count[p][6:0];
        return r;
    endfunction

    // one triangle transaction; valid may drop for a random gap unless quiet
    task automatic send_triangle(input slots_t t);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        for (int i = 0; i < TRI_SLOTS; i++)
            s_tdata[8*i +: 8] <= t[i];
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        placements_due.insert(placements_due.size(), place_triangle(t));
        sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (placements_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_limit(input int v);
        settle();
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= REG_BONE_LIMIT;
        pwdata <= 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_reg = v & 8'h7f;
        @(negedge clk);
    endtask

    function automatic slots_t random_triangle();
        slots_t t;
        int     kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < TRI_SLOTS; i++)
        begin
            if (kind == 0)
                t[i] = bone_t'($urandom_range(0, 255));
            else if ($urandom_range(0, 3) == 0)
                t[i] = '0;
            else if ($urandom_range(0, 9) == 0)
                t[i] = bone_t'($urandom_range(1, 255));
            else
                t[i] = bone_t'($urandom_range(1, 24));
        end
        return t;
    endfunction

    // results are checked as they leave, against the oldest placement due
    always @(posedge clk)
    begin
        placement_t got;
        placement_t want;
        if (m_tvalid && m_tready)
        begin
            got = placement_t'(m_tdata[16:0]);
            if (placements_due.size() == 0)
            begin
                $error("result with none due: %h", m_tdata);
                fails++;
            end
            else
            begin
                want = placements_due.pop_front();
                if (want.rejected)
                    rejects++;
                else
                    placed++;
                if (got.part != want.part)
                begin
                    $error("partition_index want %0d got %0d", want.part, got.part);
                    fails++;
                end
                if (got.opened != want.opened)
                begin
                    $error("opened_new want %0d got %0d", want.opened, got.opened);
                    fails++;
                end
                if (got.rejected != want.rejected)
                begin
                    $error("rejected want %0d got %0d", want.rejected, got.rejected);
                    fails++;
                end
                if (got.added != want.added)
                begin
                    $error("bones_added want %0d got %0d", want.added, got.added);
                    fails++;
                end
                if (got.bone_cnt != want.bone_cnt)
                begin
                    $error("partition_bone_count want %0d got %0d", want.bone_cnt,
                           got.bone_cnt);
                    fails++;
                end
            end
        end
    end

    // receiver stalls in bursts, but never when quiet
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (quiet || $urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge clk);
            end
        end
    end

    task automatic test_shapes();
        slots_t t;
        t = '{default: '0};
        send_triangle(t);                 // empty triangle opens the first partition
        t = '{default: 8'hff};
        send_triangle(t);                 // one bone in every slot
        for (int i = 0; i < TRI_SLOTS; i++)
            t[i] = bone_t'(i + 1);
        send_triangle(t);
        for (int i = 0; i < TRI_SLOTS; i++)
            t[i] = bone_t'(8'hf0 - i);
        send_triangle(t);
        t = '{default: '0};
        t[0] = 8'h01; t[5] = 8'h01; t[11] = 8'h80;
        send_triangle(t);
        t = '{default: '0};
        send_triangle(t);
    endtask

    task automatic test_limits();
        slots_t t;
        write_limit(127);                 // saturates to the partition size
        for (int i = 0; i < TRI_SLOTS; i++)
            t[i] = bone_t'(8'h40 + i);
        send_triangle(t);
        write_limit(3);
        t = '{default: '0};
        t[0] = 8'h11; t[1] = 8'h12; t[2] = 8'h13; t[3] = 8'h14;
        send_triangle(t);                 // four bones over a limit of three
        t[3] = 8'h11;
        send_triangle(t);
        send_triangle(t);
        write_limit(0);
        send_triangle(t);
        t = '{default: '0};
        send_triangle(t);
        write_limit(64);
    endtask

    task automatic test_random(input int n, input int lim);
        write_limit(lim);
        for (int k = 0; k < n; k++)
            send_triangle(random_triangle());
    endtask

    task automatic test_full_build();
        slots_t t;
        write_limit(1);
        for (int i = 0; i < 20; i++)
        begin
            t = '{default: '0};
            t[$urandom_range(0, 11)] = bone_t'(8'h90 + i);
            send_triangle(t);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cycles   = 0;
        fails    = 0;
        sent     = 0;
        placed   = 0;
        rejects  = 0;
        quiet    = 1'b0;
        parts_open = 0;
        limit_reg  = BONE_LIMIT_RST;
        for (int p = 0; p < NPART; p++)
            part_count[p] = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_shapes();
        test_limits();
        test_random(400, 64);
        test_random(250, 8);
        test_random(250, 127);
        test_random(150, 2);
        test_random(60, 0);
        test_random(250, 40);
        quiet = 1'b1;
        test_random(250, 16);
        test_full_build();

        settle();
        repeat (100) @(negedge clk);
        $display("%0d triangles sent over bone limits 0 to 127: %0d placed, %0d refused",
                 sent, placed, rejects);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
design/bpf_pkg.sv
design/bpf_dedup.sv
design/bone_partition_first_fit.sv
sim/bone_partition_first_fit_test.sv
